>>> rtl/core/camera_result_frame_parser_unit_defines.svh
// Assertion helpers for the parser modules, included by crfp_back.
`ifndef CAMERA_RESULT_FRAME_PARSER_UNIT_DEFINES_SVH
`define CAMERA_RESULT_FRAME_PARSER_UNIT_DEFINES_SVH

// Checked on every edge outside reset.
`define CRFP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked on every edge, reset included.
`define CRFP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> rtl/core/crfp_pkg.sv
package crfp_pkg;

  localparam int BYTE_W       = 8;
  localparam int FIELD_W      = 16;
  localparam int KIND_W       = 3;
  localparam int CFG_INDEX_W  = 2;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_HEADER_FIRST  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_HEADER_SECOND = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_RECORD_LIMIT  = 2'd2;

  localparam logic [BYTE_W-1:0] HEADER_FIRST_RST  = 8'h55;
  localparam logic [BYTE_W-1:0] HEADER_SECOND_RST = 8'hAA;
  localparam logic [BYTE_W-1:0] RECORD_LIMIT_RST  = 8'd16;

  localparam logic [BYTE_W-1:0] COUNT_COMMAND = 8'h29;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_FRAME_OK   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_COUNT_OK   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_BAD_HEADER = 3'd2;
  localparam logic [KIND_W-1:0] KIND_BAD_SUM    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_BLOCK      = 3'd4;
  localparam logic [KIND_W-1:0] KIND_ARROW      = 3'd5;

  localparam int RECORD_BYTES = 10;
  localparam int REC_INDEX_W  = $clog2(RECORD_BYTES);
  localparam int COUNT_BYTES  = 4;
  localparam int SUB_HDR_BYTES = 5;
  localparam int SUB_LEN_POS   = 3;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // one classified word on its way to the parser
  typedef struct packed {
    logic              timeout;
    logic              match_first;
    logic              match_second;
    logic              match_count;
    logic [BYTE_W-1:0] data;
  } item_t;

endpackage

>>> rtl/core/camera_result_frame_parser_unit.sv
// Channel   Handshake                 Payload
// byte in   byte_valid / byte_stall   op, rx_byte
// result    result_valid / result_stall  kind, command, field_a..field_e, last_record
// config    cfg_valid / cfg_ready     cfg_index, cfg_data
//
// One byte per cycle sustained while byte_stall is low; a word is loaded into the result
// register when the parser pops its byte from the queue, set by the single parser state update per byte.
// The two-slot queue between classifier and parser absorbs stalls on either side.
// rst is synchronous: parser idle, queue empty, registers back to 0x55/0xAA/16.
// cfg_ready is always high.
module camera_result_frame_parser_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [crfp_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [crfp_pkg::BYTE_W-1:0]          cfg_data,
  input  logic                                 byte_valid,
  output logic                                 byte_stall,
  input  logic                                 op,
  input  logic [crfp_pkg::BYTE_W-1:0]          rx_byte,
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output logic [crfp_pkg::KIND_W-1:0]          kind,
  output logic [crfp_pkg::BYTE_W-1:0]          command,
  output logic signed [crfp_pkg::FIELD_W-1:0]  field_a,
  output logic signed [crfp_pkg::FIELD_W-1:0]  field_b,
  output logic signed [crfp_pkg::FIELD_W-1:0]  field_c,
  output logic signed [crfp_pkg::FIELD_W-1:0]  field_d,
  output logic signed [crfp_pkg::FIELD_W-1:0]  field_e,
  output logic                                 last_record
);
  import crfp_pkg::*;

  logic              q_full;
  logic              push;
  item_t             push_item;
  logic              q_valid;
  item_t             q_item;
  logic              pop;
  logic [BYTE_W-1:0] record_limit;

  crfp_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .op           (op),
    .rx_byte      (rx_byte),
    .q_full       (q_full),
    .push         (push),
    .push_item    (push_item),
    .record_limit (record_limit)
  );

  crfp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  crfp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .pop          (pop),
    .record_limit (record_limit),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .kind         (kind),
    .command      (command),
    .field_a      (field_a),
    .field_b      (field_b),
    .field_c      (field_c),
    .field_d      (field_d),
    .field_e      (field_e),
    .last_record  (last_record)
  );

endmodule

>>> rtl/core/crfp_front.sv
module crfp_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [crfp_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [crfp_pkg::BYTE_W-1:0]        cfg_data,
  input  logic                               byte_valid,
  output logic                               byte_stall,
  input  logic                               op,
  input  logic [crfp_pkg::BYTE_W-1:0]        rx_byte,
  input  logic                               q_full,
  output logic                               push,
  output crfp_pkg::item_t                    push_item,
  output logic [crfp_pkg::BYTE_W-1:0]        record_limit
);
  import crfp_pkg::*;

  logic [BYTE_W-1:0] header_first;
  logic [BYTE_W-1:0] header_second;
  logic [BYTE_W-1:0] prev_byte;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_first  <= HEADER_FIRST_RST;
      header_second <= HEADER_SECOND_RST;
      record_limit  <= RECORD_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_HEADER_FIRST:  header_first  <= cfg_data;
        CFG_HEADER_SECOND: header_second <= cfg_data;
        CFG_RECORD_LIMIT:  record_limit  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_byte <= '0;
    end else if (push) begin
      prev_byte <= rx_byte;
    end
  end

  assign byte_stall = q_full;
  assign push       = byte_valid && !q_full;

  // compares done on entry so the parser only tests flags; the first header
  // byte is the word taken just before the second one
  always_comb begin
    push_item.timeout      = op;
    push_item.match_first  = (prev_byte == header_first);
    push_item.match_second = (rx_byte == header_second);
    push_item.match_count  = (rx_byte == COUNT_COMMAND);
    push_item.data         = rx_byte;
  end

endmodule

>>> rtl/core/crfp_queue.sv
module crfp_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  crfp_pkg::item_t  push_item,
  output logic             full,
  input  logic             pop,
  output logic             q_valid,
  output crfp_pkg::item_t  q_item
);
  import crfp_pkg::*;

  item_t                  slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;

  localparam logic [QUEUE_PTR_W-1:0] LAST_SLOT = QUEUE_PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [QUEUE_CNT_W-1:0] FULL_CNT  = QUEUE_CNT_W'(QUEUE_DEPTH);

  assign full    = (count == FULL_CNT);
  assign q_valid = (count != '0);
  assign q_item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

>>> rtl/core/crfp_back.sv
`include "camera_result_frame_parser_unit_defines.svh"

module crfp_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              q_valid,
  input  crfp_pkg::item_t                   q_item,
  output logic                              pop,
  input  logic [crfp_pkg::BYTE_W-1:0]       record_limit,
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic [crfp_pkg::KIND_W-1:0]       kind,
  output logic [crfp_pkg::BYTE_W-1:0]       command,
  output logic signed [crfp_pkg::FIELD_W-1:0] field_a,
  output logic signed [crfp_pkg::FIELD_W-1:0] field_b,
  output logic signed [crfp_pkg::FIELD_W-1:0] field_c,
  output logic signed [crfp_pkg::FIELD_W-1:0] field_d,
  output logic signed [crfp_pkg::FIELD_W-1:0] field_e,
  output logic                              last_record
);
  import crfp_pkg::*;

  localparam logic [3:0] PH_H1       = 4'd0;
  localparam logic [3:0] PH_H2       = 4'd1;
  localparam logic [3:0] PH_ADDR     = 4'd2;
  localparam logic [3:0] PH_LEN      = 4'd3;
  localparam logic [3:0] PH_CMD      = 4'd4;
  localparam logic [3:0] PH_DATA     = 4'd5;
  localparam logic [3:0] PH_SUM      = 4'd6;
  localparam logic [3:0] PH_SUB_HDR  = 4'd7;
  localparam logic [3:0] PH_SUB_DATA = 4'd8;
  localparam logic [3:0] PH_SUB_SUM  = 4'd9;

  logic [3:0]                          phase, phase_next;
  logic [BYTE_W-1:0]                   idx, idx_next;
  logic [BYTE_W-1:0]                   flen, flen_next;
  logic [BYTE_W-1:0]                   fcmd, fcmd_next;
  logic                                cmd_count, cmd_count_next;
  logic [BYTE_W-1:0]                   sum, sum_next;
  logic [COUNT_BYTES-1:0][BYTE_W-1:0]  cnt, cnt_next;
  logic [BYTE_W-1:0]                   blocks, blocks_next;
  logic [BYTE_W-1:0]                   arrows, arrows_next;
  logic [RECORD_BYTES-1:0][BYTE_W-1:0] rec, rec_next;

  logic [BYTE_W-1:0]  b;
  logic [BYTE_W-1:0]  sum_add;
  logic [BYTE_W-1:0]  idx_inc;
  logic [FIELD_W-1:0] blk_raw, arr_raw;
  logic [BYTE_W-1:0]  blk_clamp, arr_clamp;

  logic                      res_fire;
  logic [KIND_W-1:0]         res_kind;
  logic [BYTE_W-1:0]         res_cmd;
  logic [4:0][FIELD_W-1:0]   res_field;
  logic                      res_last;

  assign pop     = q_valid && (!result_valid || !result_stall);
  assign b       = q_item.data;
  assign sum_add = sum + b;
  assign idx_inc = idx + 8'd1;

  assign blk_raw   = {cnt[1], cnt[0]};
  assign arr_raw   = {cnt[3], cnt[2]};
  assign blk_clamp = (blk_raw > {8'd0, record_limit}) ? record_limit : blk_raw[BYTE_W-1:0];
  assign arr_clamp = (arr_raw > {8'd0, record_limit}) ? record_limit : arr_raw[BYTE_W-1:0];

  always_comb begin
    phase_next     = phase;
    idx_next       = idx;
    flen_next      = flen;
    fcmd_next      = fcmd;
    cmd_count_next = cmd_count;
    sum_next       = sum;
    cnt_next       = cnt;
    blocks_next    = blocks;
    arrows_next    = arrows;
    rec_next       = rec;
    res_fire       = 1'b0;
    res_kind       = KIND_FRAME_OK;
    res_cmd        = '0;
    res_field      = '0;
    res_last       = 1'b0;

    if (q_item.timeout) begin
      phase_next  = PH_H1;
      idx_next    = '0;
      blocks_next = '0;
      arrows_next = '0;
    end else begin
      unique case (phase)
        PH_H1: begin
          sum_next   = b;
          phase_next = PH_H2;
        end
        PH_H2: begin
          sum_next = sum_add;
          if (!q_item.match_first || !q_item.match_second) begin
            phase_next = PH_H1;
            res_fire   = 1'b1;
            res_kind   = KIND_BAD_HEADER;
          end else begin
            phase_next = PH_ADDR;
          end
        end
        PH_ADDR: begin
          sum_next   = sum_add;
          phase_next = PH_LEN;
        end
        PH_LEN: begin
          sum_next   = sum_add;
          flen_next  = b;
          phase_next = PH_CMD;
        end
        PH_CMD: begin
          sum_next       = sum_add;
          fcmd_next      = b;
          cmd_count_next = q_item.match_count;
          idx_next       = '0;
          cnt_next       = '0;
          phase_next     = (flen != '0) ? PH_DATA : PH_SUM;
        end
        PH_DATA: begin
          sum_next = sum_add;
          if (idx < BYTE_W'(COUNT_BYTES)) cnt_next[idx[1:0]] = b;
          idx_next = idx_inc;
          if (idx_inc >= flen) phase_next = PH_SUM;
        end
        PH_SUM: begin
          phase_next = PH_H1;
          res_fire   = 1'b1;
          res_cmd    = fcmd;
          if (b != sum) begin
            res_kind = KIND_BAD_SUM;
          end else if (!cmd_count) begin
            res_kind = KIND_FRAME_OK;
          end else begin
            res_kind     = KIND_COUNT_OK;
            res_field[0] = {8'd0, blk_clamp};
            res_field[1] = {8'd0, arr_clamp};
            blocks_next  = blk_clamp;
            arrows_next  = arr_clamp;
            if (blk_clamp != '0 || arr_clamp != '0) begin
              phase_next = PH_SUB_HDR;
              idx_next   = '0;
              flen_next  = '0;
              rec_next   = '0;
            end
          end
        end
        PH_SUB_HDR: begin
          if (idx == BYTE_W'(SUB_LEN_POS)) flen_next = b;
          idx_next = idx_inc;
          if (idx_inc >= BYTE_W'(SUB_HDR_BYTES)) begin
            idx_next   = '0;
            phase_next = (flen_next != '0) ? PH_SUB_DATA : PH_SUB_SUM;
          end
        end
        PH_SUB_DATA: begin
          if (idx < BYTE_W'(RECORD_BYTES)) rec_next[idx[REC_INDEX_W-1:0]] = b;
          idx_next = idx_inc;
          if (idx_inc >= flen) phase_next = PH_SUB_SUM;
        end
        PH_SUB_SUM: begin
          res_fire = 1'b1;
          res_cmd  = COUNT_COMMAND;
          if (blocks != '0) begin
            res_kind    = KIND_BLOCK;
            blocks_next = blocks - 8'd1;
          end else begin
            res_kind = KIND_ARROW;
            if (arrows != '0) arrows_next = arrows - 8'd1;
          end
          for (int k = 0; k < 5; k++) res_field[k] = {rec[2*k+1], rec[2*k]};
          if (blocks_next == '0 && arrows_next == '0) begin
            res_last   = 1'b1;
            phase_next = PH_H1;
            idx_next   = '0;
          end else begin
            phase_next = PH_SUB_HDR;
            idx_next   = '0;
            flen_next  = '0;
            rec_next   = '0;
          end
        end
        default: begin
          phase_next = PH_H1;
          idx_next   = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_H1;
      idx    <= '0;
      flen   <= '0;
      fcmd   <= '0;
      sum    <= '0;
      cnt    <= '0;
      blocks <= '0;
      arrows <= '0;
      rec    <= '0;
      cmd_count <= 1'b0;
    end else if (pop) begin
      phase     <= phase_next;
      idx       <= idx_next;
      flen      <= flen_next;
      fcmd      <= fcmd_next;
      sum       <= sum_next;
      cnt       <= cnt_next;
      blocks    <= blocks_next;
      arrows    <= arrows_next;
      rec       <= rec_next;
      cmd_count <= cmd_count_next;
    end
  end

  // output register; a new word may be loaded as the held one leaves
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (pop && res_fire) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && res_fire) begin
      kind        <= res_kind;
      command     <= res_cmd;
      field_a     <= signed'(res_field[0]);
      field_b     <= signed'(res_field[1]);
      field_c     <= signed'(res_field[2]);
      field_d     <= signed'(res_field[3]);
      field_e     <= signed'(res_field[4]);
      last_record <= res_last;
    end
  end

  `CRFP_ASSERT(last_only_on_records,
    (result_valid && last_record) |-> (kind == KIND_BLOCK || kind == KIND_ARROW),
    "last_record on a non-record word")
  `CRFP_ASSERT(timeout_clears_frame,
    (pop && q_item.timeout) |=> (phase == PH_H1 && blocks == '0 && arrows == '0),
    "timeout left a frame pending")
  `CRFP_ASSERT(bad_header_no_command,
    (result_valid && kind == KIND_BAD_HEADER) |-> (command == '0 && field_a == '0),
    "bad header word carries payload")
  `CRFP_ASSERT_ALWAYS(no_pop_when_empty,
    pop |-> q_valid,
    "parser consumed from an empty queue")

endmodule
